// ===== design/ghash_pkg.sv =====
// ----------------------------------------------------------------------------
// GHASH package
// Shared types and constants for the GHASH accumulator: field widths, the
// reduction constant, configuration register indexes and the command struct.
// ----------------------------------------------------------------------------
package ghash_pkg;

  // Width of one GF(2^128) element and of one half of it.
  localparam int GF_BITS   = 128;
  localparam int HALF_BITS = 64;

  // Reflected reduction polynomial R = 0xE1 || 0^120.
  localparam logic [GF_BITS-1:0] GF_REDUCE = {8'hE1, 120'd0};

  // Configuration register indexes.
  localparam int             CFG_IDX_BITS    = 1;
  localparam logic [CFG_IDX_BITS-1:0] REG_SUBKEY_HIGH = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SUBKEY_LOW  = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // take a new block and start a multiply
    logic step;    // process one digit of the subkey
    logic commit;  // move the product to the output register
  } ghash_cmd_t;

endpackage

// ===== design/ghash_ctrl.sv =====
// ----------------------------------------------------------------------------
// GHASH controller
// Sequences one block at a time: accept, digit steps, then hand-over of the
// product to the output register once that register is free.
// ----------------------------------------------------------------------------
module ghash_ctrl
  import ghash_pkg::*;
#(
  parameter int STEPS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output ghash_cmd_t cmd
);

  localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]       state;
  logic [1:0]       state_next;
  logic [CNT_W-1:0] step_cnt;
  logic             last_step;
  logic             out_free;

  // Handshake and command decode.
  assign s_axis_tready = (state == ST_IDLE);
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign last_step     = (step_cnt == CNT_W'(STEPS - 1));
  assign cmd.load      = s_axis_tvalid && s_axis_tready;
  assign cmd.step      = (state == ST_RUN);
  assign cmd.commit    = (state == ST_DONE) && out_free;

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd.load) state_next = ST_RUN;
      end
      ST_RUN: begin
        if (last_step) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State, digit counter and output beat flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      step_cnt      <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load) begin
        step_cnt <= '0;
      end else if (cmd.step) begin
        step_cnt <= step_cnt + 1'b1;
      end
      if (cmd.commit) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

endmodule

// ===== design/ghash_datapath.sv =====
// ----------------------------------------------------------------------------
// GHASH datapath
// Holds the subkey, the running hash and the digit-serial GF(2^128)
// multiplier, plus the output register.
// ----------------------------------------------------------------------------
module ghash_datapath
  import ghash_pkg::*;
#(
  parameter int DIGIT_BITS = 8,
  parameter int STEPS      = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  ghash_cmd_t              cmd,
  input  logic                    cfg_wr_en,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [HALF_BITS-1:0]    cfg_data,
  input  logic [GF_BITS-1:0]      s_axis_tdata,
  input  logic                    s_axis_tlast,
  output logic [GF_BITS-1:0]      m_axis_tdata,
  output logic                    m_axis_tlast
);

  // The multiplier register is padded with zeros below the subkey so that
  // a digit size that does not divide 128 simply runs a short last digit.
  localparam int A_BITS = STEPS * DIGIT_BITS;

  logic [HALF_BITS-1:0] subkey_high;
  logic [HALF_BITS-1:0] subkey_low;
  logic [GF_BITS-1:0]   running_hash;
  logic [A_BITS-1:0]    mult;
  logic [GF_BITS-1:0]   acc;
  logic [GF_BITS-1:0]   shifted;
  logic                 last_flag;
  logic [GF_BITS-1:0]   acc_next;
  logic [GF_BITS-1:0]   shifted_next;
  logic [GF_BITS-1:0]   block;
  logic [GF_BITS-1:0]   hash_word;

  // Fields arrive with block_high in the low half of the beat.
  assign block = {s_axis_tdata[HALF_BITS-1:0], s_axis_tdata[GF_BITS-1:HALF_BITS]};

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      subkey_high <= '0;
      subkey_low  <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_SUBKEY_HIGH: subkey_high <= cfg_data;
        REG_SUBKEY_LOW:  subkey_low  <= cfg_data;
        default: ;
      endcase
    end
  end

  // One digit of the multiply: each subkey bit, MSB first, adds the shifted
  // multiplicand, which then moves one place with reflected reduction.
  always_comb begin
    logic [GF_BITS-1:0] z;
    logic [GF_BITS-1:0] v;
    logic               carry;
    z = acc;
    v = shifted;
    for (int d = 0; d < DIGIT_BITS; d++) begin
      if (mult[A_BITS-1-d]) z = z ^ v;
      carry = v[0];
      v     = v >> 1;
      if (carry) v = v ^ GF_REDUCE;
    end
    acc_next     = z;
    shifted_next = v;
  end

  // Running hash and multiplier registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash <= '0;
    end else if (cmd.commit) begin
      running_hash <= last_flag ? '0 : acc;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      acc       <= '0;
      shifted   <= running_hash ^ block;
      mult      <= A_BITS'({subkey_high, subkey_low}) << (A_BITS - GF_BITS);
      last_flag <= s_axis_tlast;
    end else if (cmd.step) begin
      acc     <= acc_next;
      shifted <= shifted_next;
      mult    <= mult << DIGIT_BITS;
    end
  end

  // Output register, hash_high in the low half of the beat.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      hash_word    <= acc;
      m_axis_tlast <= last_flag;
    end
  end

  assign m_axis_tdata = {hash_word[HALF_BITS-1:0], hash_word[GF_BITS-1:HALF_BITS]};

endmodule

// ===== design/ghash_accumulator.sv =====
// ----------------------------------------------------------------------------
// GHASH accumulator
// Streaming GCM GHASH engine: Y = (Y xor X) * H per block, cleared after the
// block marked last.
// ----------------------------------------------------------------------------
// Each accepted block returns one beat holding the updated hash. Blocks are
// handled one at a time: a block is taken, the GF(2^128) product is formed
// DIGIT_BITS subkey bits per cycle, then the DONE state moves it into the
// output register once that register is free, and only then is a new block
// accepted. The output register lets the next block start while a result
// still waits to be taken. The subkey is written through the configuration
// port (index 0 bytes 0 to 7, index 1 bytes 8 to 15); the host must write it
// only while the block is idle, which the block itself does not enforce. The
// running hash clears after a beat with tlast set, so the host sends AAD,
// ciphertext and then the lengths block.
// ----------------------------------------------------------------------------
module ghash_accumulator
  import ghash_pkg::*;
#(
  parameter int DIGIT_BITS = 8
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_wr_en,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [HALF_BITS-1:0]    cfg_data,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [GF_BITS-1:0]      s_axis_tdata,   // block_high, block_low
  input  logic                    s_axis_tlast,   // last_block
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [GF_BITS-1:0]      m_axis_tdata,   // hash_high, hash_low
  output logic                    m_axis_tlast    // final_hash
);

  localparam int STEPS = (GF_BITS + DIGIT_BITS - 1) / DIGIT_BITS;

  ghash_cmd_t cmd;

  // Sequencing.
  ghash_ctrl #(
    .STEPS (STEPS)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cmd           (cmd)
  );

  // Arithmetic and storage.
  ghash_datapath #(
    .DIGIT_BITS (DIGIT_BITS),
    .STEPS      (STEPS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

endmodule
